// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off while reset is high
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication that also checks across reset
`define CHK_NEXT_NORST(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/lfps_pkg.sv =====
// types, constants and register codes of the line follower steering block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package lfps_pkg;

   // parameter defaults
   localparam int ADC_BITS_DEF  = 12;
   localparam int GAIN_FRAC_DEF = 12;

   // field widths
   localparam int GAIN_W     = 18;
   localparam int DUTY_W     = 7;
   localparam int ERR_W      = 14;
   localparam int TURN_W     = 2;
   localparam int CSR_W      = 18;
   localparam int CSR_IDX_W  = 3;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - 2 * DUTY_W - ERR_W;

   // internal widths
   localparam int SAMPLES    = 4;
   localparam int SMP_IDX_W  = $clog2(SAMPLES);
   localparam int MAP_W      = 10;   // mapped value 0..1000
   localparam int MAP_MUL_W  = 10;   // bits of the 1000 scale
   localparam int SUM_W      = 12;   // sum of four mapped values
   localparam int WSUM_W     = 14;   // signed weighted sum
   localparam int ERR_NUM_W  = 24;   // position dividend
   localparam int Q_W        = 13;   // quotient bits of the shared divider
   localparam int CORR_W     = 36;   // accumulated correction, Q.20
   localparam int ERR_FRAC   = 8;

   // mapping and pattern levels
   localparam int MAP_FULL  = 1000;
   localparam int ERR_SCALE = 2560;
   localparam logic [MAP_W-1:0] MAP_FULL_V = 10'd1000;
   localparam logic [MAP_W-1:0] LOST_LEVEL = 10'd400;
   localparam logic [MAP_W-1:0] HIGH_LEVEL = 10'd900;
   localparam logic [MAP_W-1:0] LOW_LEVEL  = 10'd50;

   // error and duty constants
   localparam logic signed [ERR_W-1:0] LOST_ERR  = 14'sd6400;
   localparam logic signed [ERR_W-1:0] INTEG_LIM = 14'sd7680;
   localparam logic [DUTY_W-1:0]       TURN_DUTY = 7'd70;

   // register reset values
   localparam logic [GAIN_W-1:0] GAIN_P_RST = 18'd12288;
   localparam logic [GAIN_W-1:0] GAIN_I_RST = 18'd4;
   localparam logic [GAIN_W-1:0] GAIN_D_RST = 18'd8192;
   localparam logic [DUTY_W-1:0] BASE_RST   = 7'd80;
   localparam logic [DUTY_W-1:0] DMIN_RST   = 7'd60;
   localparam logic [DUTY_W-1:0] DMAX_RST   = 7'd100;
   localparam int ADC_LOW_RST  = 1700;
   localparam int ADC_HIGH_RST = 4000;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_P   = 3'd0,
      REG_GAIN_I   = 3'd1,
      REG_GAIN_D   = 3'd2,
      REG_BASE     = 3'd3,
      REG_DUTY_MIN = 3'd4,
      REG_DUTY_MAX = 3'd5,
      REG_ADC_LOW  = 3'd6,
      REG_ADC_HIGH = 3'd7
   } csr_idx_type;

   // turn codes
   typedef enum logic [TURN_W-1:0] {
      TURN_FOLLOW = 2'd0,
      TURN_LEFT   = 2'd1,
      TURN_RIGHT  = 2'd2,
      TURN_BACK   = 2'd3
   } turn_type;

   // control from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic issue;
      logic first;
   } mac_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/lfps_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on lfps_pkg (quotient width)
`timescale 1ns / 1ps
`default_nettype none

module lfps_div #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [lfps_pkg::Q_W-1:0] quot
);
   import lfps_pkg::*;

   localparam int CNT_W = $clog2(Q_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(Q_W - 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [Q_W-1:0]   lo_ff;

   logic [DEN_W:0]   trial;
   logic             ge;
   logic [DEN_W-1:0] rem_in;
   logic [Q_W-1:0]   lo_in;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial  = {rem_ff, lo_ff[Q_W-1]};
      ge     = trial >= {1'b0, den_ff};
      rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
      lo_in  = {lo_ff[Q_W-2:0], ge};
   end

   // the quotient is known to fit Q_W bits, so the high dividend bits
   // already sit below the divisor and load straight into the remainder
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= DEN_W'(num >> Q_W);
         lo_ff  <= num[Q_W-1:0];
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         lo_ff  <= lo_in;
      end
   end

   assign done = done_ff;
   assign quot = lo_ff;

endmodule

`default_nettype wire

// ===== hdl/lfps_mac.sv =====
// shared multiply-accumulate unit for the pid terms
// depends on lfps_pkg (widths, control struct)
`timescale 1ns / 1ps
`default_nettype none

module lfps_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  lfps_pkg::mac_ctl_type         ctl,
   input  logic [lfps_pkg::GAIN_W-1:0]   gain,
   input  logic signed [lfps_pkg::ERR_W:0] opnd,
   output logic signed [lfps_pkg::CORR_W-1:0] acc
);
   import lfps_pkg::*;

   localparam int PROD_W = GAIN_W + ERR_W + 2;

   logic                     prod_vld_ff;
   logic                     prod_first_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [CORR_W-1:0] acc_ff;
   logic signed [CORR_W-1:0] acc_in;

   // unsigned gain times signed operand
   always_comb begin
      prod_in = $signed({1'b0, gain}) * opnd;
      acc_in  = prod_first_ff ? CORR_W'(prod_ff) : acc_ff + CORR_W'(prod_ff);
   end

   // product register control
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff   <= 1'b0;
         prod_first_ff <= 1'b0;
      end else begin
         prod_vld_ff   <= ctl.issue;
         prod_first_ff <= ctl.first;
      end
   end

   // product and accumulator
   always_ff @(posedge clock) begin
      if (ctl.issue) begin
         prod_ff <= prod_in;
      end
      if (prod_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

// ===== hdl/line_follow_pid_steering.sv =====
// line follower steering: sample mapping, centroid, pid and duty clamp
// depends on lfps_pkg, lfps_div and lfps_mac
//
//   channel | direction | handshake          | payload
//   req     | in        | req_tvalid/tready  | tdata: sample_0..sample_3
//   rsp     | out       | rsp_tvalid/tready  | tdata: duties, line_error; tuser: turn
//   csr     | in        | csr_we             | csr_index, csr_wdata
//
// one item at a time; its result is loaded after these steps: each clamped sample is
// mapped directly, each other sample goes through the shared 13-step divider, then
// classify, decide and load; a line item adds pid, mac, duties and, unless the line
// is lost, the position division
// reset restores the register defaults and clears last error and integral.
// a finished result waits in the output register; the next item can be taken in the cycle
// after the load and only finishes once that register is free.
`timescale 1ns / 1ps
`default_nettype none

module line_follow_pid_steering #(
   parameter int ADC_BITS       = lfps_pkg::ADC_BITS_DEF,
   parameter int GAIN_FRAC_BITS = lfps_pkg::GAIN_FRAC_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // sample_0, sample_1, sample_2, sample_3, zero pad
   input  logic [((4*ADC_BITS+7)/8)*8-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // left_duty, right_duty, line_error, zero pad
   output logic [lfps_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // turn_code
   output logic [lfps_pkg::TURN_W-1:0]          rsp_tuser,
   input  logic                                 csr_we,
   input  logic [lfps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lfps_pkg::CSR_W-1:0]           csr_wdata
);
   import lfps_pkg::*;

   localparam int NUM_W = (ADC_BITS + MAP_MUL_W > ERR_NUM_W) ? ADC_BITS + MAP_MUL_W : ERR_NUM_W;
   localparam int DEN_W = (ADC_BITS > SUM_W) ? ADC_BITS : SUM_W;
   localparam int PF    = GAIN_FRAC_BITS + ERR_FRAC;
   localparam int T_W   = ((PF + DUTY_W + 1 > CORR_W) ? PF + DUTY_W + 1 : CORR_W) + 2;
   localparam logic [1:0] MAC_DRAIN = 2'd3;
   localparam logic [SMP_IDX_W-1:0] SMP_LAST = SMP_IDX_W'(SAMPLES - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_MAP, S_MAPW, S_CLASS, S_DECIDE, S_ERRW,
      S_PID, S_MAC, S_DUTYL, S_DUTYR, S_DONE
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [GAIN_W-1:0]   gain_p_ff, gain_i_ff, gain_d_ff;
   logic [DUTY_W-1:0]   base_ff, dmin_ff, dmax_ff;
   logic [ADC_BITS-1:0] adc_low_ff, adc_high_ff;

   // item and working registers
   logic [ADC_BITS-1:0]      samp_ff [SAMPLES];
   logic [MAP_W-1:0]         v_ff    [SAMPLES];
   logic [SMP_IDX_W-1:0]     idx_ff;
   turn_type                 turn_ff;
   logic                     lost_ff;
   logic [SUM_W-1:0]         sum_ff;
   logic signed [WSUM_W-1:0] wsum_ff;
   logic signed [ERR_W-1:0]  err_ff;
   logic signed [ERR_W:0]    diff_ff;
   logic signed [ERR_W-1:0]  last_err_ff;
   logic signed [ERR_W-1:0]  integ_ff;
   logic [1:0]               mac_cnt_ff;
   logic [DUTY_W-1:0]        left_ff, right_ff;

   // result register
   logic                     rsp_valid_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;
   logic [TURN_W-1:0]        rsp_user_ff;

   // combinational next values
   logic [ADC_BITS-1:0]      x_cur;
   logic                     map_direct;
   logic [MAP_W-1:0]         map_v;
   logic [ADC_BITS-1:0]      map_dx;
   logic [NUM_W-1:0]         map_num;
   logic [SUM_W-1:0]         sum_in;
   logic [WSUM_W-1:0]        wsum_in;
   turn_type                 turn_in;
   logic                     lost_in;
   logic [WSUM_W-1:0]        mag;
   logic [NUM_W-1:0]         err_num;
   logic signed [ERR_W-1:0]  err_div_in;
   logic signed [ERR_W:0]    diff_in;
   logic signed [ERR_W:0]    acc_sum;
   logic signed [ERR_W-1:0]  integ_in;
   logic signed [T_W-1:0]    corr_ext, corr_sel, t_val;
   logic [T_W-1:0]           base_sh, min_sh, max_sh;
   logic [DUTY_W-1:0]        duty_in;

   // divider and mac hookup
   logic                     div_start;
   logic [NUM_W-1:0]         div_num;
   logic [DEN_W-1:0]         div_den;
   logic                     div_done;
   logic [Q_W-1:0]           div_quot;
   mac_ctl_type              mac_ctl;
   logic [GAIN_W-1:0]        mac_gain;
   logic signed [ERR_W:0]    mac_opnd;
   logic signed [CORR_W-1:0] corr;

   lfps_div #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (div_num),
      .den  (div_den),
      .done (div_done),
      .quot (div_quot)
   );

   lfps_mac u_mac (
      .clock(clock),
      .reset(reset),
      .ctl  (mac_ctl),
      .gain (mac_gain),
      .opnd (mac_opnd),
      .acc  (corr)
   );

   // sample mapping: clamp cases directly, interior through the divider
   always_comb begin
      x_cur   = samp_ff[idx_ff];
      map_dx  = x_cur - adc_low_ff;
      map_num = NUM_W'(map_dx) * NUM_W'(MAP_FULL);
      map_direct = 1'b1;
      map_v      = '0;
      if (adc_high_ff <= adc_low_ff) begin
         map_v = (x_cur >= adc_high_ff) ? MAP_FULL_V : '0;
      end else if (x_cur <= adc_low_ff) begin
         map_v = '0;
      end else if (x_cur >= adc_high_ff) begin
         map_v = MAP_FULL_V;
      end else begin
         map_direct = 1'b0;
      end
   end

   // turn patterns, centroid sums and lost-line test
   always_comb begin
      sum_in  = SUM_W'(v_ff[0]) + SUM_W'(v_ff[1]) + SUM_W'(v_ff[2]) + SUM_W'(v_ff[3]);
      wsum_in = WSUM_W'(v_ff[0]) * WSUM_W'(3) + WSUM_W'(v_ff[1])
              - WSUM_W'(v_ff[2]) - WSUM_W'(v_ff[3]) * WSUM_W'(3);
      lost_in = !((v_ff[0] > LOST_LEVEL) || (v_ff[1] > LOST_LEVEL) ||
                  (v_ff[2] > LOST_LEVEL) || (v_ff[3] > LOST_LEVEL));
      if (v_ff[0] < LOW_LEVEL && v_ff[1] > HIGH_LEVEL &&
          v_ff[2] > HIGH_LEVEL && v_ff[3] > HIGH_LEVEL) begin
         turn_in = TURN_LEFT;
      end else if (v_ff[0] > HIGH_LEVEL && v_ff[1] > HIGH_LEVEL &&
                   v_ff[2] > HIGH_LEVEL && v_ff[3] < LOW_LEVEL) begin
         turn_in = TURN_RIGHT;
      end else if (v_ff[0] > HIGH_LEVEL && v_ff[1] > HIGH_LEVEL &&
                   v_ff[2] > HIGH_LEVEL && v_ff[3] > HIGH_LEVEL) begin
         turn_in = TURN_BACK;
      end else begin
         turn_in = TURN_FOLLOW;
      end
   end

   // position dividend, rounded to nearest by adding half the divisor
   always_comb begin
      mag        = wsum_ff[WSUM_W-1] ? WSUM_W'(-wsum_ff) : WSUM_W'(wsum_ff);
      err_num    = NUM_W'(mag) * NUM_W'(ERR_SCALE) + NUM_W'(sum_ff >> 1);
      err_div_in = wsum_ff[WSUM_W-1] ? -$signed(ERR_W'(div_quot)) : $signed(ERR_W'(div_quot));
   end

   // divider operand select
   always_comb begin
      div_start = 1'b0;
      div_num   = map_num;
      div_den   = DEN_W'(adc_high_ff - adc_low_ff);
      if (state_ff == S_MAP) begin
         div_start = !map_direct;
      end else if (state_ff == S_DECIDE) begin
         div_start = (turn_ff == TURN_FOLLOW) && !lost_ff;
         div_num   = err_num;
         div_den   = DEN_W'(sum_ff);
      end
   end

   // pid difference and saturated integral
   always_comb begin
      diff_in = (ERR_W + 1)'(err_ff) - (ERR_W + 1)'(last_err_ff);
      acc_sum = (ERR_W + 1)'(integ_ff) + (ERR_W + 1)'(err_ff);
      if (acc_sum > (ERR_W + 1)'(INTEG_LIM)) begin
         integ_in = INTEG_LIM;
      end else if (acc_sum < -(ERR_W + 1)'(INTEG_LIM)) begin
         integ_in = -INTEG_LIM;
      end else begin
         integ_in = acc_sum[ERR_W-1:0];
      end
   end

   // mac operand sequence: p * error, i * integral, d * difference
   always_comb begin
      mac_ctl.issue = (state_ff == S_MAC) && (mac_cnt_ff != MAC_DRAIN);
      mac_ctl.first = (mac_cnt_ff == 2'd0);
      case (mac_cnt_ff)
         2'd0: begin
            mac_gain = gain_p_ff;
            mac_opnd = (ERR_W + 1)'(err_ff);
         end
         2'd1: begin
            mac_gain = gain_i_ff;
            mac_opnd = (ERR_W + 1)'(integ_ff);
         end
         2'd2: begin
            mac_gain = gain_d_ff;
            mac_opnd = diff_ff;
         end
         default: begin
            mac_gain = '0;
            mac_opnd = '0;
         end
      endcase
   end

   // duty from base plus or minus correction, clamped, rounded half up
   always_comb begin
      corr_ext = T_W'(corr);
      corr_sel = (state_ff == S_DUTYR) ? -corr_ext : corr_ext;
      base_sh  = T_W'(base_ff) << PF;
      min_sh   = T_W'(dmin_ff) << PF;
      max_sh   = T_W'(dmax_ff) << PF;
      t_val    = $signed(base_sh) + corr_sel;
      if (t_val < $signed(min_sh)) begin
         duty_in = dmin_ff;
      end else if (t_val > $signed(max_sh)) begin
         duty_in = dmax_ff;
      end else begin
         duty_in = t_val[PF +: DUTY_W] + DUTY_W'(t_val[PF-1]);
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff   <= GAIN_P_RST;
         gain_i_ff   <= GAIN_I_RST;
         gain_d_ff   <= GAIN_D_RST;
         base_ff     <= BASE_RST;
         dmin_ff     <= DMIN_RST;
         dmax_ff     <= DMAX_RST;
         adc_low_ff  <= ADC_BITS'(ADC_LOW_RST);
         adc_high_ff <= ADC_BITS'(ADC_HIGH_RST);
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            REG_GAIN_P:   gain_p_ff   <= csr_wdata[GAIN_W-1:0];
            REG_GAIN_I:   gain_i_ff   <= csr_wdata[GAIN_W-1:0];
            REG_GAIN_D:   gain_d_ff   <= csr_wdata[GAIN_W-1:0];
            REG_BASE:     base_ff     <= csr_wdata[DUTY_W-1:0];
            REG_DUTY_MIN: dmin_ff     <= csr_wdata[DUTY_W-1:0];
            REG_DUTY_MAX: dmax_ff     <= csr_wdata[DUTY_W-1:0];
            REG_ADC_LOW:  adc_low_ff  <= csr_wdata[ADC_BITS-1:0];
            REG_ADC_HIGH: adc_high_ff <= csr_wdata[ADC_BITS-1:0];
            default: ;
         endcase
      end
   end

   // sequencer, working state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         mac_cnt_ff   <= '0;
         last_err_ff  <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the done state reloads the result register itself
         if (rsp_valid_ff && rsp_tready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  for (int i = 0; i < SAMPLES; i++) begin
                     samp_ff[i] <= req_tdata[i*ADC_BITS +: ADC_BITS];
                  end
                  idx_ff   <= '0;
                  state_ff <= S_MAP;
               end
            end
            S_MAP: begin
               if (map_direct) begin
                  v_ff[idx_ff] <= map_v;
                  idx_ff       <= idx_ff + 1'b1;
                  state_ff     <= (idx_ff == SMP_LAST) ? S_CLASS : S_MAP;
               end else begin
                  state_ff <= S_MAPW;
               end
            end
            S_MAPW: begin
               if (div_done) begin
                  v_ff[idx_ff] <= div_quot[MAP_W-1:0];
                  idx_ff       <= idx_ff + 1'b1;
                  state_ff     <= (idx_ff == SMP_LAST) ? S_CLASS : S_MAP;
               end
            end
            S_CLASS: begin
               turn_ff  <= turn_in;
               lost_ff  <= lost_in;
               sum_ff   <= sum_in;
               wsum_ff  <= $signed(wsum_in);
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if (turn_ff != TURN_FOLLOW) begin
                  left_ff  <= TURN_DUTY;
                  right_ff <= TURN_DUTY;
                  err_ff   <= last_err_ff;
                  state_ff <= S_DONE;
               end else if (lost_ff) begin
                  err_ff   <= (last_err_ff > 0) ? LOST_ERR : -LOST_ERR;
                  state_ff <= S_PID;
               end else begin
                  state_ff <= S_ERRW;
               end
            end
            S_ERRW: begin
               if (div_done) begin
                  err_ff   <= err_div_in;
                  state_ff <= S_PID;
               end
            end
            S_PID: begin
               diff_ff     <= diff_in;
               integ_ff    <= integ_in;
               last_err_ff <= err_ff;
               mac_cnt_ff  <= '0;
               state_ff    <= S_MAC;
            end
            S_MAC: begin
               mac_cnt_ff <= mac_cnt_ff + 1'b1;
               if (mac_cnt_ff == MAC_DRAIN) begin
                  state_ff <= S_DUTYL;
               end
            end
            S_DUTYL: begin
               left_ff  <= duty_in;
               state_ff <= S_DUTYR;
            end
            S_DUTYR: begin
               right_ff <= duty_in;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {{RSP_PAD_W{1'b0}}, err_ff, right_ff, left_ff};
                  rsp_user_ff  <= turn_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// ===== hdl/lfps_checker.sv =====
// port-level checks of the line follower steering block, bound to the top
// depends on lfps_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lfps_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [lfps_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [lfps_pkg::TURN_W-1:0]     rsp_tuser
);
   import lfps_pkg::*;

   logic signed [ERR_W-1:0] rsp_err;
   logic [DUTY_W-1:0]       rsp_left;
   logic [DUTY_W-1:0]       rsp_right;

   assign rsp_left  = rsp_tdata[0 +: DUTY_W];
   assign rsp_right = rsp_tdata[DUTY_W +: DUTY_W];
   assign rsp_err   = $signed(rsp_tdata[2*DUTY_W +: ERR_W]);

   // no result survives reset
   `CHK_NEXT_NORST(a_rst_clear, clock, reset, !rsp_tvalid)

   // one item at a time: the block is busy right after taking an item
   `CHK_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

   // a stalled result holds
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // turn items drive both motors at the fixed turn duty
   `CHK_IMPLY(a_turn_duty, clock, reset, rsp_tvalid && (rsp_tuser != TURN_FOLLOW), (rsp_left == TURN_DUTY) && (rsp_right == TURN_DUTY))

   // the reported error never leaves the position range
   `CHK_IMPLY(a_err_range, clock, reset, rsp_tvalid, (rsp_err <= INTEG_LIM) && (rsp_err >= -INTEG_LIM))

endmodule

bind line_follow_pid_steering lfps_checker u_lfps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

`default_nettype wire
